// File: design/ffsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared widths, command and status codes, segment entry type
// ----------------------------------------------------------------------------
package ffsa_pkg;
   localparam int MaxSegments = 16;
   localparam int AddrBits    = 16;
   localparam int OwnerBits   = 8;
   localparam int IdxBits     = $clog2(MaxSegments);
   localparam int CntBits     = $clog2(MaxSegments + 1);
   localparam int VirtBits    = AddrBits + 1;
   localparam int SizeBits    = AddrBits + 1;

   localparam logic [2:0] CMD_INIT    = 3'd0;
   localparam logic [2:0] CMD_ALLOC   = 3'd1;
   localparam logic [2:0] CMD_ACCESS  = 3'd2;
   localparam logic [2:0] CMD_RELEASE = 3'd3;
   localparam logic [2:0] CMD_CLEAR   = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_OVERLAP = 3'd1;
   localparam logic [2:0] ST_NOMEM   = 3'd2;
   localparam logic [2:0] ST_ACCESS  = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   typedef struct packed {
      logic [AddrBits-1:0]  ps;
      logic [AddrBits-1:0]  pe;
      logic [OwnerBits-1:0] owner;
      logic                 used;
      logic [VirtBits-1:0]  vs;
      logic [VirtBits-1:0]  ve;
   } seg_type;

   // result of the shared per-entry test unit
   typedef struct packed {
      logic overlap;
      logic fits;
      logic covers;
      logic mine;
   } test_type;
endpackage

// File: design/ffsa_test_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_test_unit
// compares one segment entry against the request, used once per step
// ----------------------------------------------------------------------------
module ffsa_test_unit (
   input  ffsa_pkg::seg_type                      seg,
   input  logic [ffsa_pkg::OwnerBits-1:0]         owner,
   input  logic [ffsa_pkg::AddrBits-1:0]          base,
   input  logic [ffsa_pkg::AddrBits-1:0]          len,
   output ffsa_pkg::test_type                     res
);
   import ffsa_pkg::*;
   logic [VirtBits:0] b, e, last, vs, ve;
   logic [AddrBits:0] diff;
   always_comb begin
      b    = (VirtBits+1)'(base);
      e    = (VirtBits+1)'(base) + (VirtBits+1)'(len);
      // last is base + len, one past the end of the range: compare via ve + 1
      last = e;
      vs   = (VirtBits+1)'(seg.vs);
      ve   = (VirtBits+1)'(seg.ve);
      diff = (AddrBits+1)'(seg.pe) - (AddrBits+1)'(seg.ps);
      res.overlap = (vs <= b && ve > b) || (vs < e && ve > e);
      res.fits    = (seg.pe >= seg.ps) && (diff[AddrBits-1:0] >= len);
      res.mine    = seg.used && (seg.owner == owner);
      res.covers  = res.mine && (vs <= b) && (ve + 1'b1 >= last);
   end
endmodule

// File: design/first_fit_segment_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// first-fit segment allocator with a sixteen-entry segment table
// ----------------------------------------------------------------------------
// a transaction is taken when start is high and busy is low; busy is high
// while it runs and is low again when the status is shown on rsp_status for
// one cycle with rsp_valid; init, clear and a zero-length allocate never
// raise busy. the receiver cannot stall, so the result must be captured in
// that cycle. one shared test unit looks at one table entry a cycle; an entry
// shift or merge moves one entry a cycle. allocate scans for the first free
// entry that fits, then shifts the entries above the fit and splits it;
// access scans for an owned entry that covers the range; release frees all
// entries of the owner, then merges free neighbours one at a time. csr writes
// are taken only while busy and start are both low.
module first_fit_segment_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_cmd,
   input  logic [ffsa_pkg::OwnerBits-1:0] req_owner_id,
   input  logic [15:0]                   req_virt_base,
   input  logic [15:0]                   req_length,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [16:0]                   csr_mem_size
);
   import ffsa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_SHIFT, S_SPLIT, S_FREE, S_MERGE, S_MOVE
   } state_type;

   state_type              state_ff;
   seg_type                tab_ff [MaxSegments];
   logic [CntBits-1:0]     count_ff;
   logic [IdxBits-1:0]     idx_ff, j_ff;
   logic [16:0]            size_ff;
   logic [2:0]             cmd_ff;
   logic [OwnerBits-1:0]   owner_ff;
   logic [AddrBits-1:0]    base_ff, len_ff;
   logic                   done_ff;
   logic [2:0]             status_ff;

   seg_type                cur;
   test_type               tst;
   logic [SizeBits-1:0]    clamp;
   seg_type                split_own, split_rest, freed_seg;

   // one free segment spanning 0 .. pe
   function automatic seg_type fresh_seg(input logic [AddrBits-1:0] pe);
      fresh_seg    = '0;
      fresh_seg.pe = pe;
   endfunction

   // the single shared compare unit, pointed at the current entry
   assign cur = tab_ff[idx_ff];
   ffsa_test_unit u_test (
      .seg(cur), .owner(owner_ff), .base(base_ff), .len(len_ff), .res(tst)
   );

   always_comb begin
      clamp = size_ff;
      if (size_ff == '0) clamp = SizeBits'(1);
      if (size_ff > (SizeBits'(1) << AddrBits)) clamp = SizeBits'(1) << AddrBits;
   end

   // owned front part and free rest of a split, and a freed entry
   always_comb begin
      split_own       = cur;
      split_own.pe    = cur.ps + len_ff - 1'b1;
      split_own.used  = 1'b1;
      split_own.owner = owner_ff;
      split_own.vs    = VirtBits'(base_ff);
      split_own.ve    = VirtBits'(base_ff) + VirtBits'(len_ff) - 1'b1;
      split_rest      = '0;
      split_rest.ps   = cur.ps + len_ff;
      split_rest.pe   = cur.pe;
      freed_seg       = cur;
      freed_seg.used  = 1'b0;
      freed_seg.owner = '0;
      freed_seg.vs    = '0;
      freed_seg.ve    = '0;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_valid = done_ff;
   assign rsp_status = status_ff;

   logic in_range, last_pair;
   assign in_range  = (CntBits'(idx_ff) < count_ff);
   assign last_pair = (CntBits'(idx_ff) + CntBits'(1) >= count_ff);

   always_ff @(posedge clock) begin : seq_proc
      logic done_in;
      done_in = 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= 17'd1024;
         count_ff <= CntBits'(1);
         for (int k = 1; k < MaxSegments; k++) begin
            tab_ff[k] <= '0;
         end
         tab_ff[0] <= fresh_seg(AddrBits'(1023));
         idx_ff <= '0;
         j_ff <= '0;
         status_ff <= ST_OK;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid && csr_ready) size_ff <= csr_mem_size;
               if (start) begin
                  cmd_ff    <= req_cmd;
                  owner_ff  <= req_owner_id;
                  base_ff   <= req_virt_base;
                  len_ff    <= req_length;
                  idx_ff    <= '0;
                  status_ff <= (req_cmd == CMD_ALLOC && req_length == '0) ?
                               ST_NOMEM : ST_OK;
                  unique case (req_cmd)
                     CMD_INIT: begin
                        for (int k = 1; k < MaxSegments; k++) tab_ff[k] <= '0;
                        tab_ff[0] <= fresh_seg(AddrBits'(clamp - SizeBits'(1)));
                        count_ff <= CntBits'(1);
                        done_in  = 1'b1;
                     end
                     CMD_CLEAR: begin
                        for (int k = 0; k < MaxSegments; k++) tab_ff[k] <= '0;
                        count_ff <= '0;
                        done_in  = 1'b1;
                     end
                     CMD_ALLOC: begin
                        if (req_length == '0) done_in = 1'b1;
                        else state_ff <= S_SCAN;
                     end
                     CMD_ACCESS:  state_ff <= S_SCAN;
                     CMD_RELEASE: state_ff <= S_FREE;
                     default: done_in = 1'b1;
                  endcase
               end
            end
            S_SCAN: begin
               if (!in_range) begin
                  status_ff <= (cmd_ff == CMD_ALLOC) ? ST_NOMEM : ST_ACCESS;
                  done_in = 1'b1;
                  state_ff <= S_IDLE;
               end else if (cmd_ff == CMD_ACCESS) begin
                  if (tst.covers) begin
                     done_in = 1'b1;
                     state_ff <= S_IDLE;
                  end else if (idx_ff == IdxBits'(MaxSegments - 1)) begin
                     status_ff <= ST_ACCESS;
                     done_in = 1'b1;
                     state_ff <= S_IDLE;
                  end else idx_ff <= idx_ff + 1'b1;
               end else if (cur.used) begin
                  if (tst.overlap) begin
                     status_ff <= ST_OVERLAP;
                     done_in = 1'b1;
                     state_ff <= S_IDLE;
                  end else if (idx_ff == IdxBits'(MaxSegments - 1)) begin
                     status_ff <= ST_NOMEM;
                     done_in = 1'b1;
                     state_ff <= S_IDLE;
                  end else idx_ff <= idx_ff + 1'b1;
               end else if (tst.fits) begin
                  if (count_ff >= CntBits'(MaxSegments)) begin
                     status_ff <= ST_FULL;
                     done_in = 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     j_ff <= IdxBits'(count_ff);
                     state_ff <= S_SHIFT;
                  end
               end else if (idx_ff == IdxBits'(MaxSegments - 1)) begin
                  status_ff <= ST_NOMEM;
                  done_in = 1'b1;
                  state_ff <= S_IDLE;
               end else idx_ff <= idx_ff + 1'b1;
            end
            // open a hole at idx+1, one entry per cycle from the top down
            S_SHIFT: begin
               if (j_ff > idx_ff + 1'b1) begin
                  tab_ff[j_ff] <= tab_ff[j_ff - 1'b1];
                  j_ff <= j_ff - 1'b1;
               end else state_ff <= S_SPLIT;
            end
            S_SPLIT: begin
               tab_ff[idx_ff + 1'b1] <= split_rest;
               tab_ff[idx_ff]        <= split_own;
               count_ff <= count_ff + 1'b1;
               done_in  = 1'b1;
               state_ff <= S_IDLE;
            end
            S_FREE: begin
               if (in_range && tst.mine) tab_ff[idx_ff] <= freed_seg;
               if (!in_range || idx_ff == IdxBits'(MaxSegments - 1)) begin
                  idx_ff <= '0;
                  state_ff <= S_MERGE;
               end else idx_ff <= idx_ff + 1'b1;
            end
            S_MERGE: begin
               if (last_pair) begin
                  done_in = 1'b1;
                  state_ff <= S_IDLE;
               end else if (!cur.used && !tab_ff[idx_ff + 1'b1].used) begin
                  tab_ff[idx_ff].pe <= tab_ff[idx_ff + 1'b1].pe;
                  j_ff <= idx_ff + 1'b1;
                  state_ff <= S_MOVE;
               end else idx_ff <= idx_ff + 1'b1;
            end
            // close the gap, one entry per cycle, then clear the top entry
            S_MOVE: begin
               if (CntBits'(j_ff) + CntBits'(1) < count_ff) begin
                  tab_ff[j_ff] <= tab_ff[j_ff + 1'b1];
                  j_ff <= j_ff + 1'b1;
               end else begin
                  tab_ff[j_ff] <= '0;
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_MERGE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
      done_ff <= done_in;
   end
endmodule

// File: design/ffsa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_checker
// port-level checks of the allocator handshake
// ----------------------------------------------------------------------------
module ffsa_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [2:0] rsp_status,
   input logic       csr_ready
);
   import ffsa_pkg::*;
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL) else $error("bad status");
   a_nocsr: assert property (@(posedge clock) disable iff (reset)
      busy |-> !csr_ready) else $error("csr ready while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("done while busy");
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid || $past(start)) else $error("done held");
endmodule

bind first_fit_segment_allocator_top ffsa_checker u_ffsa_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status), .csr_ready(csr_ready)
);
